@@ rtl/dnup_pkg.sv @@
// ----------------------------------------------------------------------------
// dnup_pkg
// Shared types, codes and the base letter lookup for the 2-bit DNA unpacker.
// ----------------------------------------------------------------------------
package dnup_pkg;

    localparam int DEFAULT_MAX_RUNS = 16;

    localparam int POS_W    = 32;
    localparam int CHAR_W   = 8;
    localparam int S_DATA_W = 104;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 40;
    localparam int M_USER_W = 3;

    localparam logic [CHAR_W-1:0] UNKNOWN_CHAR = 8'h4E;  // 'N'

    // configuration register indexes
    localparam logic REG_BEGIN_POS = 1'b0;
    localparam logic REG_END_POS   = 1'b1;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_BYTE  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_WINDOW = 2'd1,
        STATUS_OVERFLOW   = 2'd2
    } status_t;

    // write request into the unknown-base run table
    typedef struct packed {
        logic             en;
        logic [POS_W-1:0] first;
        logic [POS_W:0]   last;
    } run_wr_t;

    function automatic logic [CHAR_W-1:0] base_letter(input logic [1:0] code);
        logic [CHAR_W-1:0] ch;
        case (code)
            2'd0:    ch = 8'h54;  // T
            2'd1:    ch = 8'h43;  // C
            2'd2:    ch = 8'h41;  // A
            2'd3:    ch = 8'h47;  // G
            default: ch = 8'h54;
        endcase
        return ch;
    endfunction

endpackage

@@ rtl/two_bit_dna_unpacker.sv @@
// ----------------------------------------------------------------------------
// two_bit_dna_unpacker
// Decodes one 2-bit packed genome record over a 1-based window, marking bases
// in loaded unknown-base runs as N and flagging window and table errors.
// ----------------------------------------------------------------------------
// flow: an accepted word is walked in the work stage, each result word then
//   goes to the output register; start and run words without an error give none
// walk: a byte word steps pair by pair up to the end base; pairs before begin_pos
//   emit nothing; a held output stalls it; a new word enters as the walk ends
// reset: synchronous active-low aresetn clears control state; the run table
//   is undefined until loaded and only entries below the run count are used
module two_bit_dna_unpacker import dnup_pkg::*; #(
    parameter int MAX_RUNS = DEFAULT_MAX_RUNS
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [POS_W-1:0]    cfg_wdata,

    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // ref_length[31:0], run_start[63:32], run_size[95:64], packed_byte[103:96]
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    // mode[1:0]
    input  logic [S_USER_W-1:0] s_axis_tuser,

    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // base_char[7:0], position[39:8]
    output logic [M_DATA_W-1:0] m_axis_tdata,
    // is_base[0], status[2:1]
    output logic [M_USER_W-1:0] m_axis_tuser,
    output logic                m_axis_tlast
);

    localparam int CNT_W = $clog2(MAX_RUNS + 1);
    localparam int IDX_W = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;

    // configuration
    logic [POS_W-1:0] begin_reg;
    logic [POS_W-1:0] end_reg;

    // window state
    logic [POS_W-1:0] next_pos_reg, next_pos_next;
    logic [POS_W-1:0] eff_end_reg, eff_end_next;
    logic [CNT_W-1:0] run_count_reg, run_count_next;
    logic             win_error_reg, win_error_next;
    logic             win_done_reg, win_done_next;

    // work stage: one byte walked pair by pair, or one pending status word
    logic             st_busy_reg, st_busy_next;
    logic             st_is_status_reg, st_is_status_next;
    status_t          st_status_reg, st_status_next;
    logic [7:0]       st_byte_reg, st_byte_next;
    logic [POS_W-1:0] st_base_reg, st_base_next;
    logic [1:0]       st_idx_reg, st_idx_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0] m_char_reg, m_char_next;
    logic [POS_W-1:0]  m_pos_reg, m_pos_next;
    logic              m_is_base_reg, m_is_base_next;
    logic              m_last_reg, m_last_next;
    status_t           m_status_reg, m_status_next;

    // input fields
    mode_t            in_mode;
    logic [POS_W-1:0] in_ref_length;
    logic [POS_W-1:0] in_run_start;
    logic [POS_W-1:0] in_run_size;
    logic [7:0]       in_byte;

    logic             accept;
    logic             out_ready;
    logic             st_step;
    logic             st_done;
    logic             emit;
    logic [POS_W:0]   pos;
    logic [1:0]       pair_code;
    logic             below_begin;
    logic             at_end;
    logic             unknown_hit;
    logic             table_full;
    logic [POS_W-1:0] start_eff_end;
    logic [POS_W-1:0] begin_m1;
    run_wr_t          run_wr;

    assign in_mode       = mode_t'(s_axis_tuser[1:0]);
    assign in_ref_length = s_axis_tdata[31:0];
    assign in_run_start  = s_axis_tdata[63:32];
    assign in_run_size   = s_axis_tdata[95:64];
    assign in_byte       = s_axis_tdata[103:96];

    assign table_full    = (run_count_reg >= CNT_W'(MAX_RUNS));
    assign start_eff_end = (end_reg > in_ref_length) ? in_ref_length : end_reg;
    assign begin_m1      = begin_reg - POS_W'(1);

    // pair walk
    assign out_ready   = !m_valid_reg || m_axis_tready;
    assign pos         = {1'b0, st_base_reg} + {{(POS_W-1){1'b0}}, st_idx_reg};
    assign below_begin = (pos < {1'b0, begin_reg});
    assign at_end      = (pos == {1'b0, eff_end_reg});
    assign st_step     = st_busy_reg && out_ready;
    assign emit        = st_step && (st_is_status_reg || !below_begin);
    assign st_done     = st_step && (st_is_status_reg || at_end || (st_idx_reg == 2'd3));

    assign s_axis_tready = !st_busy_reg || st_done;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        case (st_idx_reg)
            2'd0:    pair_code = st_byte_reg[7:6];
            2'd1:    pair_code = st_byte_reg[5:4];
            2'd2:    pair_code = st_byte_reg[3:2];
            2'd3:    pair_code = st_byte_reg[1:0];
            default: pair_code = st_byte_reg[7:6];
        endcase
    end

    dnup_run_table #(
        .MAX_RUNS (MAX_RUNS),
        .CNT_W    (CNT_W),
        .IDX_W    (IDX_W)
    ) u_run_table (
        .aclk      (aclk),
        .wr        (run_wr),
        .wr_idx    (run_count_reg[IDX_W-1:0]),
        .run_count (run_count_reg),
        .pos       (pos),
        .hit       (unknown_hit)
    );

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            begin_reg <= POS_W'(1);
            end_reg   <= '1;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_BEGIN_POS: begin_reg <= cfg_wdata;
                REG_END_POS:   end_reg   <= cfg_wdata;
                default:       begin_reg <= begin_reg;
            endcase
        end
    end

    // input decode: window state and stage load
    always_comb begin
        next_pos_next     = next_pos_reg;
        eff_end_next      = eff_end_reg;
        run_count_next    = run_count_reg;
        win_error_next    = win_error_reg;
        win_done_next     = win_done_reg;
        st_busy_next      = st_busy_reg;
        st_is_status_next = st_is_status_reg;
        st_status_next    = st_status_reg;
        st_byte_next      = st_byte_reg;
        st_base_next      = st_base_reg;
        st_idx_next       = st_idx_reg;
        run_wr.en         = 1'b0;
        run_wr.first      = in_run_start;
        run_wr.last       = {1'b0, in_run_start} + {1'b0, in_run_size};

        if (st_done) begin
            st_busy_next = 1'b0;
        end else if (st_step) begin
            st_idx_next = st_idx_reg + 2'd1;
        end

        if (accept) begin
            st_busy_next = 1'b0;
            st_idx_next  = 2'd0;
            case (in_mode)
                MODE_START: begin
                    eff_end_next   = start_eff_end;
                    run_count_next = '0;
                    if ((begin_reg == '0) || (begin_reg > start_eff_end)) begin
                        win_error_next    = 1'b1;
                        win_done_next     = 1'b1;
                        next_pos_next     = '0;
                        st_busy_next      = 1'b1;
                        st_is_status_next = 1'b1;
                        st_status_next    = STATUS_BAD_WINDOW;
                    end else begin
                        win_error_next = 1'b0;
                        win_done_next  = 1'b0;
                        // first position of the byte holding begin_pos
                        next_pos_next  = {begin_m1[POS_W-1:2], 2'b01};
                    end
                end
                MODE_RUN: begin
                    if (table_full) begin
                        st_busy_next      = 1'b1;
                        st_is_status_next = 1'b1;
                        st_status_next    = STATUS_OVERFLOW;
                    end else begin
                        run_wr.en      = 1'b1;
                        run_count_next = run_count_reg + CNT_W'(1);
                    end
                end
                MODE_BYTE: begin
                    if (!win_done_reg && !win_error_reg) begin
                        st_busy_next      = 1'b1;
                        st_is_status_next = 1'b0;
                        st_byte_next      = in_byte;
                        st_base_next      = next_pos_reg;
                        next_pos_next     = next_pos_reg + POS_W'(4);
                        // window closes once its end lies inside this byte
                        win_done_next     = (({1'b0, next_pos_reg} + (POS_W+1)'(3)) >=
                                             {1'b0, eff_end_reg});
                    end
                end
                default: begin
                    st_busy_next = 1'b0;
                end
            endcase
        end
    end

    // output register load
    always_comb begin
        m_valid_next   = m_valid_reg;
        m_char_next    = m_char_reg;
        m_pos_next     = m_pos_reg;
        m_is_base_next = m_is_base_reg;
        m_last_next    = m_last_reg;
        m_status_next  = m_status_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            if (st_is_status_reg) begin
                m_char_next    = '0;
                m_pos_next     = '0;
                m_is_base_next = 1'b0;
                m_last_next    = 1'b0;
                m_status_next  = st_status_reg;
            end else begin
                m_char_next    = unknown_hit ? UNKNOWN_CHAR : base_letter(pair_code);
                m_pos_next     = pos[POS_W-1:0];
                m_is_base_next = 1'b1;
                m_last_next    = at_end;
                m_status_next  = STATUS_OK;
            end
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_pos_reg  <= '0;
            eff_end_reg   <= '0;
            run_count_reg <= '0;
            win_error_reg <= 1'b0;
            win_done_reg  <= 1'b1;
            st_busy_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            next_pos_reg  <= next_pos_next;
            eff_end_reg   <= eff_end_next;
            run_count_reg <= run_count_next;
            win_error_reg <= win_error_next;
            win_done_reg  <= win_done_next;
            st_busy_reg   <= st_busy_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        st_is_status_reg <= st_is_status_next;
        st_status_reg    <= st_status_next;
        st_byte_reg      <= st_byte_next;
        st_base_reg      <= st_base_next;
        st_idx_reg       <= st_idx_next;
        m_char_reg       <= m_char_next;
        m_pos_reg        <= m_pos_next;
        m_is_base_reg    <= m_is_base_next;
        m_last_reg       <= m_last_next;
        m_status_reg     <= m_status_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_pos_reg, m_char_reg};
    assign m_axis_tuser  = {m_status_reg, m_is_base_reg};
    assign m_axis_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_run_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        run_count_reg <= CNT_W'(MAX_RUNS))
        else $error("run count beyond table size");

    a_last_is_base: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser[0])
        else $error("last flag on a status word");

    a_base_status_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tuser[2:1] == STATUS_OK))
        else $error("base word carries an error status");

    a_no_accept_mid_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_busy_reg && !st_step) |-> !s_axis_tready)
        else $error("input taken while the work stage is stalled");
`endif

endmodule

@@ rtl/dnup_run_table.sv @@
// ----------------------------------------------------------------------------
// dnup_run_table
// Unknown-base run table: holds loaded runs and flags a position inside any
// valid run.
// ----------------------------------------------------------------------------
module dnup_run_table import dnup_pkg::*; #(
    parameter int MAX_RUNS = DEFAULT_MAX_RUNS,
    parameter int CNT_W    = $clog2(MAX_RUNS + 1),
    parameter int IDX_W    = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1
) (
    input  logic             aclk,
    input  run_wr_t          wr,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [CNT_W-1:0] run_count,
    input  logic [POS_W:0]   pos,
    output logic             hit
);

    logic [POS_W-1:0] first_reg [MAX_RUNS];
    logic [POS_W:0]   last_reg  [MAX_RUNS];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            first_reg[wr_idx] <= wr.first;
            last_reg[wr_idx]  <= wr.last;
        end
    end

    // run covers 1-based positions first+1 .. last
    always_comb begin
        hit = 1'b0;
        for (int i = 0; i < MAX_RUNS; i++) begin
            if ((CNT_W'(i) < run_count) && (pos > {1'b0, first_reg[i]}) &&
                (pos <= last_reg[i])) begin
                hit = 1'b1;
            end
        end
    end

endmodule

@@ tb/sv/dnup_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnup_result_checker
// Watches the register port and both stream channels of the 2-bit DNA
// unpacker. It keeps its own copy of the window and run table state, works
// out the base and status words each accepted input word should cause, and
// compares every output word against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module dnup_result_checker import dnup_pkg::*; #(
    parameter int MAX_RUNS = DEFAULT_MAX_RUNS
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [POS_W-1:0]    cfg_wdata,

    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    // ref_length[31:0], run_start[63:32], run_size[95:64], packed_byte[103:96]
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    // mode[1:0]
    input  logic [S_USER_W-1:0] s_axis_tuser,

    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // base_char[7:0], position[39:8]
    input  logic [M_DATA_W-1:0] m_axis_tdata,
    // is_base[0], status[2:1]
    input  logic [M_USER_W-1:0] m_axis_tuser,
    input  logic                m_axis_tlast,

    output int                  pending_results,
    output int                  mismatches
);

    typedef struct packed {
        logic [CHAR_W-1:0] base_char;
        logic [POS_W-1:0]  position;
        logic              is_base;
        logic              last;
        status_t           status;
    } base_result_t;

    localparam logic [CHAR_W-1:0] BASE_LETTERS [4] = '{"T", "C", "A", "G"};

    base_result_t      expected_bases [$];

    logic [POS_W-1:0]  begin_reg;
    logic [POS_W-1:0]  end_reg;
    logic [POS_W-1:0]  next_pos;
    logic [POS_W-1:0]  win_end;
    logic [POS_W-1:0]  run_lo [MAX_RUNS];
    logic [POS_W:0]    run_hi [MAX_RUNS];
    int                run_cnt;
    logic              win_err;
    logic              win_done;

    function automatic string show(base_result_t r);
        return $sformatf("char=%h pos=%0d is_base=%b last=%b status=%0d",
                         r.base_char, r.position, r.is_base, r.last, r.status);
    endfunction

    function automatic bit in_unknown_run(logic [POS_W:0] pos);
        for (int i = 0; i < run_cnt; i++) begin
            if (pos > {1'b0, run_lo[i]} && pos <= run_hi[i])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // append one expected word at the tail of the queue
    task automatic queue_result(base_result_t r);
        expected_bases.insert(expected_bases.size(), r);
    endtask

    task automatic add_status(status_t code);
        base_result_t r;
        r = '0;
        r.status = code;
        queue_result(r);
    endtask

    task automatic decode_word(logic [S_USER_W-1:0] mode, logic [S_DATA_W-1:0] data);
        logic [POS_W-1:0]  len;
        logic [POS_W-1:0]  rs;
        logic [POS_W-1:0]  rsz;
        logic [7:0]        pb;
        logic [POS_W:0]    pos;
        logic [1:0]        code;
        base_result_t      r;
        len = data[31:0];
        rs  = data[63:32];
        rsz = data[95:64];
        pb  = data[103:96];
        case (mode)
            MODE_START: begin
                win_end = (end_reg > len) ? len : end_reg;
                run_cnt = 0;
                if (begin_reg == '0 || begin_reg > win_end) begin
                    win_err  = 1'b1;
                    win_done = 1'b1;
                    next_pos = '0;
                    add_status(STATUS_BAD_WINDOW);
                end else begin
                    win_err  = 1'b0;
                    win_done = 1'b0;
                    // first byte is the one holding begin_pos
                    next_pos = ((begin_reg - 32'd1) & ~32'd3) + 32'd1;
                end
            end
            MODE_RUN: begin
                if (run_cnt >= MAX_RUNS) begin
                    add_status(STATUS_OVERFLOW);
                end else begin
                    run_lo[run_cnt] = rs;
                    run_hi[run_cnt] = {1'b0, rs} + {1'b0, rsz};
                    run_cnt++;
                end
            end
            MODE_BYTE: begin
                if (!win_done && !win_err) begin
                    for (int k = 0; k < 4; k++) begin
                        pos  = {1'b0, next_pos} + (POS_W+1)'(k);
                        code = pb[7 - 2*k -: 2];
                        if (pos < {1'b0, begin_reg})
                            continue;
                        if (pos > {1'b0, win_end})
                            break;
                        r.base_char = in_unknown_run(pos) ? UNKNOWN_CHAR : BASE_LETTERS[code];
                        r.position  = pos[POS_W-1:0];
                        r.is_base   = 1'b1;
                        r.last      = (pos == {1'b0, win_end});
                        r.status    = STATUS_OK;
                        queue_result(r);
                        if (r.last) begin
                            win_done = 1'b1;
                            break;
                        end
                    end
                    next_pos = next_pos + 32'd4;
                end
            end
            default: ;  // unused mode is dropped
        endcase
    endtask

    always @(posedge aclk) begin
        base_result_t got;
        base_result_t want;
        if (!aresetn) begin
            begin_reg  = 32'd1;
            end_reg    = '1;
            next_pos   = '0;
            win_end    = '0;
            run_cnt    = 0;
            win_err    = 1'b0;
            win_done   = 1'b1;
            mismatches = 0;
            expected_bases.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.base_char = m_axis_tdata[7:0];
                got.position  = m_axis_tdata[39:8];
                got.is_base   = m_axis_tuser[0];
                got.status    = status_t'(m_axis_tuser[2:1]);
                got.last      = m_axis_tlast;
                if (expected_bases.size() == 0) begin
                    $display("%0t: output word with none expected, actual %s",
                             $time, show(got));
                    mismatches++;
                end else begin
                    want = expected_bases.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch, expected %s, actual %s",
                                 $time, show(want), show(got));
                        mismatches++;
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_BEGIN_POS: begin_reg = cfg_wdata;
                    REG_END_POS:   end_reg   = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                decode_word(s_axis_tuser, s_axis_tdata);
        end
        pending_results <= expected_bases.size();
    end

endmodule

@@ tb/sv/tb_two_bit_dna_unpacker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_bit_dna_unpacker
// Drives records into the 2-bit DNA unpacker: a short directed set of window
// corner cases, then random records (start, unknown-base runs, packed bytes)
// under changing window settings and stall patterns. Checking is done by
// dnup_result_checker.
// ----------------------------------------------------------------------------
module tb_two_bit_dna_unpacker;
    import dnup_pkg::*;

    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         RANDOM_WORDS = 250;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         TIMEOUT_NS   = 10_000_000;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                cfg_we        = 1'b0;
    logic                cfg_index     = REG_BEGIN_POS;
    logic [POS_W-1:0]    cfg_wdata     = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic [S_USER_W-1:0] s_axis_tuser  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic [M_USER_W-1:0] m_axis_tuser;
    logic                m_axis_tlast;

    int pending_results;
    int mismatches;
    int src_idle_pct = 17;
    int dst_idle_pct = 84;
    int sent_words   = 0;

    two_bit_dna_unpacker u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    dnup_result_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .m_axis_tlast    (m_axis_tlast),
        .pending_results (pending_results),
        .mismatches      (mismatches)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk)
        m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);

    initial begin
        #TIMEOUT_NS;
        $display("** two_bit_dna_unpacker: FAILED **");
        $finish;
    end

    function automatic logic [POS_W-1:0] sat_add(logic [POS_W-1:0] a, int unsigned k);
        logic [POS_W:0] sum;
        sum = {1'b0, a} + k;
        return sum[POS_W] ? '1 : sum[POS_W-1:0];
    endfunction

    // valid stays high from one word to the next unless a gap is taken
    task automatic send_word(logic [1:0] mode, logic [31:0] len, logic [31:0] rs,
                             logic [31:0] rsz, logic [7:0] pb);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pb, rsz, rs, len};
        s_axis_tuser  <= mode;
        do @(posedge aclk); while (!s_axis_tready);
        sent_words++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_window(logic [31:0] first_pos, logic [31:0] last_pos);
        cfg_we    <= 1'b1;
        cfg_index <= REG_BEGIN_POS;
        cfg_wdata <= first_pos;
        @(posedge aclk);
        cfg_index <= REG_END_POS;
        cfg_wdata <= last_pos;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_run(logic [31:0] first, int unsigned span);
        if ($urandom_range(0, 5) == 0)
            send_word(MODE_RUN, $urandom, $urandom, $urandom, 8'($urandom));
        else
            send_word(MODE_RUN, $urandom, first - 32'd2 + $urandom_range(0, span),
                      $urandom_range(0, 6), 8'($urandom));
    endtask

    task automatic send_record(logic [31:0] b, logic [31:0] e, int rec);
        logic [31:0] len;
        logic [31:0] eff;
        logic [31:0] first;
        logic        err;
        int          nbytes;
        int          nruns;
        int unsigned span;
        case ($urandom_range(0, 4))
            0:       len = $urandom;
            1:       len = sat_add(b, $urandom_range(0, 40));
            2:       len = b - 32'd1;
            3:       len = '1;
            default: len = '0;
        endcase
        first = ((b - 32'd1) & ~32'd3) + 32'd1;
        eff   = (e > len) ? len : e;
        // keep the window to a handful of bytes
        if (b != '0 && b <= eff && eff - first > 64) begin
            len = sat_add(b, $urandom_range(0, 40));
            eff = (e > len) ? len : e;
        end
        err  = (b == '0) || (b > eff);
        span = err ? 8 : eff - first + 3;

        // noise and stray words ahead of the start
        if ($urandom_range(0, 9) == 0)
            send_word(MODE_BYTE, $urandom, $urandom, $urandom, 8'($urandom));
        if ($urandom_range(0, 19) == 0)
            send_word(MODE_UNUSED, $urandom, $urandom, $urandom, 8'($urandom));
        if ($urandom_range(0, 9) == 0)
            send_run(first, span);

        send_word(MODE_START, len, $urandom, $urandom, 8'($urandom));
        nruns = (rec % 7 == 3) ? $urandom_range(17, 19) : $urandom_range(0, 4);
        repeat (nruns) send_run(first, span);

        nbytes = err ? $urandom_range(0, 2) : int'((eff - first) >> 2) + 1;
        if ($urandom_range(0, 6) == 0)
            nbytes = $urandom_range(0, nbytes);
        else if ($urandom_range(0, 4) == 0)
            nbytes++;
        repeat (nbytes) begin
            if ($urandom_range(0, 7) == 0)
                send_run(first, span);
            send_word(MODE_BYTE, $urandom, $urandom, $urandom, 8'($urandom));
        end
    endtask

    initial begin
        logic [31:0] b;
        logic [31:0] e;
        int          rec;
        int          done;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // bytes before any start and the unused mode give nothing
        send_word(MODE_BYTE, '0, '0, '0, 8'hFF);
        send_word(MODE_UNUSED, '1, '1, '1, 8'hFF);
        wait_drained();
        write_window(32'd1, 32'hFFFF_FFFF);
        // six-base record, empty run, position 3 unknown, byte past the end
        send_word(MODE_START, 32'd6, '0, '0, '0);
        send_word(MODE_RUN, '0, 32'd0, 32'd0, '0);
        send_word(MODE_RUN, '0, 32'd2, 32'd1, '0);
        send_word(MODE_BYTE, '0, '0, '0, 8'h1B);
        send_word(MODE_BYTE, '0, '0, '0, 8'hE4);
        send_word(MODE_BYTE, '0, '0, '0, 8'h00);
        // empty record is a bad window, byte after it is dropped
        send_word(MODE_START, 32'd0, '0, '0, '0);
        send_word(MODE_BYTE, '0, '0, '0, 8'h55);
        wait_drained();
        // window at the top of the position range, run end past 32 bits
        write_window(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_word(MODE_START, 32'hFFFF_FFFF, '0, '0, '0);
        send_word(MODE_RUN, '0, 32'hFFFF_FFFE, 32'hFFFF_FFFF, '0);
        send_word(MODE_BYTE, '0, '0, '0, 8'hB1);
        wait_drained();
        // begin of zero
        write_window(32'd0, 32'd100);
        send_word(MODE_START, 32'd50, '0, '0, '0);

        rec  = 0;
        done = sent_words;
        while (done < RANDOM_WORDS) begin
            if (done < RANDOM_WORDS / 3) begin
                src_idle_pct = 17;
                dst_idle_pct = 84;
            end else if (done < 2 * RANDOM_WORDS / 3) begin
                src_idle_pct = 84;
                dst_idle_pct = 17;
            end else begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end
            case ($urandom_range(0, 5))
                0: begin
                    b = $urandom_range(1, 12);
                    e = b + $urandom_range(0, 40);
                end
                1: begin
                    b = $urandom;
                    e = sat_add(b, $urandom_range(0, 40));
                end
                2: begin
                    e = '1;
                    b = e - $urandom_range(0, 40);
                end
                3: begin
                    b = $urandom_range(1, 20);
                    e = '1;
                end
                4: begin
                    b = '0;
                    e = $urandom;
                end
                default: begin
                    b = $urandom_range(5, 60);
                    e = b - $urandom_range(1, 4);
                end
            endcase
            wait_drained();
            write_window(b, e);
            repeat ($urandom_range(2, 4)) begin
                // hold the sender off until the output side has caught up
                if ($urandom_range(0, 5) == 0)
                    wait_drained();
                send_record(b, e, rec);
                rec++;
            end
            done = sent_words;
        end

        wait_drained();
        if (mismatches == 0)
            $display("** two_bit_dna_unpacker: PASSED **");
        else
            $display("** two_bit_dna_unpacker: FAILED **");
        $finish;
    end

endmodule
